// ----- sv/emg_three_biquad_cascade_macros.svh -----
// Assertion macros for the three-biquad cascade.
// Depends on a clock named clk and a synchronous reset named rst in the using scope.
`ifndef EMG_THREE_BIQUAD_CASCADE_MACROS_SVH
`define EMG_THREE_BIQUAD_CASCADE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ETBC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define ETBC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/etbc_pkg.sv -----
// Shared constants, types and control structs for the three-biquad cascade.
// No dependencies; the files that use it refer to it by scoped names.
package etbc_pkg;

  // Sample and coefficient formats
  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 18;
  localparam int COEF_FRAC = 16;

  // Filter structure
  localparam int SECTIONS  = 3;
  localparam int SEC_W     = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int NUM_TAPS  = 3;
  localparam int DEN_TAPS  = 2;
  localparam int NUM_W     = NUM_TAPS * COEF_W;
  localparam int DEN_W     = DEN_TAPS * COEF_W;

  // Configuration port: numerator and denominator register per section
  localparam int NUM_REGS   = 2 * SECTIONS;
  localparam int CFG_IDX_W  = $clog2(NUM_REGS);
  localparam int CFG_DATA_W = NUM_W;
  localparam logic [NUM_W-1:0] NUM_RESET = NUM_W'(1) << COEF_FRAC;

  // History memory: four entries per section, addressed {section, slot}
  localparam int SLOT_W    = 2;
  localparam int ADDR_W    = SEC_W + SLOT_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  // Datapath widths: product, and accumulator with headroom for five terms plus rounding
  localparam int PROD_W = COEF_W + SAMPLE_W;
  localparam int ACC_W  = PROD_W + 3;

  typedef enum logic [SLOT_W-1:0] {
    SLOT_X1,
    SLOT_X2,
    SLOT_Y1,
    SLOT_Y2
  } slot_t;

  typedef enum logic [2:0] {
    TERM_B0,
    TERM_B1,
    TERM_B2,
    TERM_A1,
    TERM_A2
  } term_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  // Per-cycle control from the sequencer to the MAC unit
  typedef struct packed {
    logic    mul_en;
    acc_op_t acc_op;
    logic    sat_en;
  } mac_ctl_t;

endpackage

// ----- sv/emg_three_biquad_cascade.sv -----
// Three direct-form-I biquads in series (high-pass, low-pass, notch) on 24-bit
// signed samples, one filtered sample out per sample in. Each item occupies the
// block from its accept cycle until it sits in the output register, and no new
// sample is taken meanwhile. After the accept step come the sections in order,
// then the output load. Each section runs five multiplies through the single
// shared 18x24 multiplier, a step to fold the last product into the accumulator,
// and four write-backs through the one write port of the history RAM. Round and
// saturate are registered during the first write-back. The output load waits
// while the previous result sits untaken on the master side. The next sample is
// taken while a finished result still waits on the master side. History starts
// at zero after reset through per-entry valid bits, so there is no clearing
// pass. Coefficients (signed Q2.16, packed per section) must be written through
// the cfg port only while the block is idle; the block does not enforce this.
// Depends on etbc_pkg, etbc_ram, etbc_coef, etbc_mac and the macros header.
`include "emg_three_biquad_cascade_macros.svh"

module emg_three_biquad_cascade (
  input  logic                                clk,
  input  logic                                rst,
  // Input sample stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [etbc_pkg::SAMPLE_W-1:0]       s_tdata,   // [23:0] sample_in
  // Output sample stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [etbc_pkg::SAMPLE_W-1:0]       m_tdata,   // [23:0] sample_out
  // Coefficient write port
  input  logic                                cfg_we,
  input  logic [etbc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [etbc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam logic [etbc_pkg::SEC_W-1:0] LAST_SEC = etbc_pkg::SEC_W'(etbc_pkg::SECTIONS - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_B0,
    ST_B1,
    ST_B2,
    ST_A1,
    ST_A2,
    ST_ACC,
    ST_WX2,
    ST_WX1,
    ST_WY2,
    ST_WY1,
    ST_OUT
  } state_t;

  state_t                               state;
  logic [etbc_pkg::SEC_W-1:0]           sec;
  logic signed [etbc_pkg::SAMPLE_W-1:0] cur;
  logic signed [etbc_pkg::SAMPLE_W-1:0] hx1;
  logic signed [etbc_pkg::SAMPLE_W-1:0] hy1;
  logic [etbc_pkg::MEM_DEPTH-1:0]       valid;
  logic                                 rd_ok;

  etbc_pkg::slot_t                      rd_slot;
  etbc_pkg::slot_t                      wr_slot;
  logic [etbc_pkg::ADDR_W-1:0]          raddr;
  logic [etbc_pkg::ADDR_W-1:0]          waddr;
  logic                                 wr_en;
  logic [etbc_pkg::SAMPLE_W-1:0]        wdata;
  logic [etbc_pkg::SAMPLE_W-1:0]        rdata;
  logic signed [etbc_pkg::SAMPLE_W-1:0] hist;

  etbc_pkg::term_t                      term;
  etbc_pkg::mac_ctl_t                   mac_ctl;
  logic signed [etbc_pkg::COEF_W-1:0]   coef;
  logic signed [etbc_pkg::SAMPLE_W-1:0] mac_data;
  logic signed [etbc_pkg::SAMPLE_W-1:0] y;

  assign s_tready = (state == ST_IDLE);

  // History entries never written read as zero
  assign hist     = rd_ok ? $signed(rdata) : '0;
  assign mac_data = (state == ST_B0) ? cur : hist;
  assign raddr    = {sec, rd_slot};
  assign waddr    = {sec, wr_slot};

  // Per-state read slot, coefficient term, MAC control and history write
  always_comb begin
    rd_slot = etbc_pkg::SLOT_X1;
    term    = etbc_pkg::TERM_B0;
    mac_ctl = '{mul_en: 1'b0, acc_op: etbc_pkg::ACC_HOLD, sat_en: 1'b0};
    wr_en   = 1'b0;
    wr_slot = etbc_pkg::SLOT_X1;
    wdata   = '0;
    unique case (state)
      ST_B0: begin
        rd_slot = etbc_pkg::SLOT_X1;
        term    = etbc_pkg::TERM_B0;
        mac_ctl.mul_en = 1'b1;
      end
      ST_B1: begin
        rd_slot = etbc_pkg::SLOT_X2;
        term    = etbc_pkg::TERM_B1;
        mac_ctl.mul_en = 1'b1;
        mac_ctl.acc_op = etbc_pkg::ACC_LOAD;
      end
      ST_B2: begin
        rd_slot = etbc_pkg::SLOT_Y1;
        term    = etbc_pkg::TERM_B2;
        mac_ctl.mul_en = 1'b1;
        mac_ctl.acc_op = etbc_pkg::ACC_ADD;
      end
      ST_A1: begin
        rd_slot = etbc_pkg::SLOT_Y2;
        term    = etbc_pkg::TERM_A1;
        mac_ctl.mul_en = 1'b1;
        mac_ctl.acc_op = etbc_pkg::ACC_ADD;
      end
      ST_A2: begin
        term    = etbc_pkg::TERM_A2;
        mac_ctl.mul_en = 1'b1;
        mac_ctl.acc_op = etbc_pkg::ACC_SUB;
      end
      ST_ACC: begin
        mac_ctl.acc_op = etbc_pkg::ACC_SUB;
      end
      ST_WX2: begin
        mac_ctl.sat_en = 1'b1;
        wr_en   = 1'b1;
        wr_slot = etbc_pkg::SLOT_X2;
        wdata   = hx1;
      end
      ST_WX1: begin
        wr_en   = 1'b1;
        wr_slot = etbc_pkg::SLOT_X1;
        wdata   = cur;
      end
      ST_WY2: begin
        wr_en   = 1'b1;
        wr_slot = etbc_pkg::SLOT_Y2;
        wdata   = hy1;
      end
      ST_WY1: begin
        wr_en   = 1'b1;
        wr_slot = etbc_pkg::SLOT_Y1;
        wdata   = y;
      end
      default: begin
      end
    endcase
  end

  // Valid bits: cleared at reset, set on each history write
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_ok <= 1'b0;
    end else begin
      rd_ok <= valid[raddr];
      if (wr_en) begin
        valid[waddr] <= 1'b1;
      end
    end
  end

  // Sequencer: sections in order, reads ahead of write-backs so no entry overlaps
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      sec      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // Output register empties once taken, unless reloaded below
      if (m_tready && (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cur   <= $signed(s_tdata);
            sec   <= '0;
            state <= ST_B0;
          end
        end
        ST_B0:  state <= ST_B1;
        ST_B1: begin
          hx1   <= hist;
          state <= ST_B2;
        end
        ST_B2:  state <= ST_A1;
        ST_A1: begin
          hy1   <= hist;
          state <= ST_A2;
        end
        ST_A2:  state <= ST_ACC;
        ST_ACC: state <= ST_WX2;
        ST_WX2: state <= ST_WX1;
        ST_WX1: state <= ST_WY2;
        ST_WY2: state <= ST_WY1;
        ST_WY1: begin
          cur <= y;
          if (sec == LAST_SEC) begin
            sec   <= '0;
            state <= ST_OUT;
          end else begin
            sec   <= sec + 1'b1;
            state <= ST_B0;
          end
        end
        ST_OUT: begin
          // Wait for the output register to be free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= cur;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  etbc_ram #(
    .WIDTH (etbc_pkg::SAMPLE_W),
    .DEPTH (etbc_pkg::MEM_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  etbc_coef u_coef (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sec       (sec),
    .term      (term),
    .coef      (coef)
  );

  etbc_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .coef (coef),
    .data (mac_data),
    .y    (y)
  );

  // Checks on sequencing
  `ETBC_ASSERT_NXT(a_accept_starts, s_tvalid && s_tready,
    (state == ST_B0) && (sec == '0), "accepted sample did not start at the first section")
  `ETBC_ASSERT_NXT(a_last_to_out, (state == ST_WY1) && (sec == LAST_SEC),
    state == ST_OUT, "last section write-back not followed by output load")
  `ETBC_ASSERT_IMP(a_out_from_seq, $rose(m_tvalid), $past(state == ST_OUT),
    "result appeared without finishing the cascade")

endmodule

// ----- sv/etbc_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module etbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/etbc_coef.sv -----
// Coefficient register file: takes configuration writes, selects one coefficient.
// Depends on etbc_pkg.
module etbc_coef (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [etbc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [etbc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [etbc_pkg::SEC_W-1:0]          sec,
  input  etbc_pkg::term_t                     term,
  output logic signed [etbc_pkg::COEF_W-1:0]  coef
);

  logic [etbc_pkg::NUM_W-1:0] num [etbc_pkg::SECTIONS];
  logic [etbc_pkg::DEN_W-1:0] den [etbc_pkg::SECTIONS];

  logic [etbc_pkg::SEC_W-1:0] wr_sec;
  logic                       wr_den;
  logic [etbc_pkg::NUM_W-1:0] num_sel;
  logic [etbc_pkg::DEN_W-1:0] den_sel;

  // Index bit 0 picks denominator, upper bits pick the section
  assign wr_den = cfg_index[0];
  assign wr_sec = cfg_index[etbc_pkg::CFG_IDX_W-1:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < etbc_pkg::SECTIONS; s++) begin
        num[s] <= etbc_pkg::NUM_RESET;
        den[s] <= '0;
      end
    end else if (cfg_we && (32'(cfg_index) < etbc_pkg::NUM_REGS)) begin
      if (wr_den) begin
        den[wr_sec] <= cfg_data[etbc_pkg::DEN_W-1:0];
      end else begin
        num[wr_sec] <= cfg_data[etbc_pkg::NUM_W-1:0];
      end
    end
  end

  assign num_sel = num[sec];
  assign den_sel = den[sec];

  // Field select for the current term
  always_comb begin
    unique case (term)
      etbc_pkg::TERM_B0: coef = num_sel[0*etbc_pkg::COEF_W +: etbc_pkg::COEF_W];
      etbc_pkg::TERM_B1: coef = num_sel[1*etbc_pkg::COEF_W +: etbc_pkg::COEF_W];
      etbc_pkg::TERM_B2: coef = num_sel[2*etbc_pkg::COEF_W +: etbc_pkg::COEF_W];
      etbc_pkg::TERM_A1: coef = den_sel[0*etbc_pkg::COEF_W +: etbc_pkg::COEF_W];
      etbc_pkg::TERM_A2: coef = den_sel[1*etbc_pkg::COEF_W +: etbc_pkg::COEF_W];
      default:           coef = '0;
    endcase
  end

endmodule

// ----- sv/etbc_mac.sv -----
// Shared multiply-accumulate unit with rounding and saturation to sample width.
// Depends on etbc_pkg.
module etbc_mac (
  input  logic                                  clk,
  input  etbc_pkg::mac_ctl_t                    ctl,
  input  logic signed [etbc_pkg::COEF_W-1:0]    coef,
  input  logic signed [etbc_pkg::SAMPLE_W-1:0]  data,
  output logic signed [etbc_pkg::SAMPLE_W-1:0]  y
);

  localparam int ACC_W    = etbc_pkg::ACC_W;
  localparam int PROD_W   = etbc_pkg::PROD_W;
  localparam int SAMPLE_W = etbc_pkg::SAMPLE_W;

  localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) << (etbc_pkg::COEF_FRAC - 1);
  localparam logic signed [ACC_W-1:0] SMAX  =
    {{(ACC_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SMIN  = ~SMAX;

  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    shifted;
  logic signed [SAMPLE_W-1:0] y_next;

  // Product register ahead of the accumulator
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= coef * data;
    end
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  // Accumulator; the load carries the rounding half
  always_ff @(posedge clk) begin
    unique case (ctl.acc_op)
      etbc_pkg::ACC_HOLD: acc <= acc;
      etbc_pkg::ACC_LOAD: acc <= ROUND + prod_ext;
      etbc_pkg::ACC_ADD:  acc <= acc + prod_ext;
      etbc_pkg::ACC_SUB:  acc <= acc - prod_ext;
      default:            acc <= acc;
    endcase
  end

  // Floor shift, then clamp to the signed sample range
  assign shifted = acc >>> etbc_pkg::COEF_FRAC;

  always_comb begin
    if (shifted > SMAX) begin
      y_next = SMAX[SAMPLE_W-1:0];
    end else if (shifted < SMIN) begin
      y_next = SMIN[SAMPLE_W-1:0];
    end else begin
      y_next = shifted[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sat_en) begin
      y <= y_next;
    end
  end

endmodule

// ----- test/emg_three_biquad_cascade_tb.sv -----
// Self-checking testbench for emg_three_biquad_cascade: directed and random samples through
// the three-biquad cascade, checked against an in-bench fixed-point filter model.
// Depends on etbc_pkg and the emg_three_biquad_cascade RTL.
`timescale 1ns / 100ps

module emg_three_biquad_cascade_tb;

  // Package constants used here
  localparam int SAMPLE_W   = etbc_pkg::SAMPLE_W;
  localparam int COEF_W     = etbc_pkg::COEF_W;
  localparam int COEF_FRAC  = etbc_pkg::COEF_FRAC;
  localparam int SECTIONS   = etbc_pkg::SECTIONS;
  localparam int NUM_W      = etbc_pkg::NUM_W;
  localparam int DEN_W      = etbc_pkg::DEN_W;
  localparam int NUM_REGS   = etbc_pkg::NUM_REGS;
  localparam int CFG_IDX_W  = etbc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = etbc_pkg::CFG_DATA_W;
  localparam logic [NUM_W-1:0] NUM_RESET = etbc_pkg::NUM_RESET;

  // Run sizing
  localparam int RESET_CYCLES    = 4;
  localparam int SETTLE_CYCLES   = 40;    // long enough for one item to pass through the block
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int HOLD_AT         = 330;   // outputs seen before the long receiver hold-off
  localparam int LONG_HOLD       = 400;

  // Coefficient corner values, signed Q2.16
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC;
  localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic [COEF_W-1:0] COEF_ZERO = '0;
  localparam logic [COEF_W-1:0] JUNK_BITS = '1;

  // Sample rails
  localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_W-1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  // Coefficient register map, including two unmapped indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HP_NUM,
    REG_HP_DEN,
    REG_LP_NUM,
    REG_LP_DEN,
    REG_NOTCH_NUM,
    REG_NOTCH_DEN,
    REG_UNMAPPED_A,
    REG_UNMAPPED_B
  } coef_reg_e;

  typedef enum int {
    STYLE_IDENTITY,
    STYLE_TAME,
    STYLE_WILD,
    STYLE_MAX,
    STYLE_MIN
  } coef_style_e;

  // Directed stimulus row: sample, and an expected output where it is obvious
  typedef struct packed {
    logic [SAMPLE_W-1:0] smp;
    logic                typed;
    logic [SAMPLE_W-1:0] out;
  } vector_t;

  localparam int N_DIRECTED  = 20;
  localparam int FIRST_STRESS = 8;

  // Rows before FIRST_STRESS run with reset coefficients (pass-through);
  // the rest run with corner coefficients that drive every section into the rails.
  vector_t directed [N_DIRECTED] = '{
    '{24'h000000, 1'b1, 24'h000000},
    '{24'h000001, 1'b1, 24'h000001},
    '{24'hFFFFFF, 1'b1, 24'hFFFFFF},
    '{24'h7FFFFF, 1'b1, 24'h7FFFFF},
    '{24'h800000, 1'b1, 24'h800000},
    '{24'h555555, 1'b1, 24'h555555},
    '{24'hAAAAAA, 1'b1, 24'hAAAAAA},
    '{24'h000000, 1'b1, 24'h000000},
    '{24'h7FFFFF, 1'b0, 24'h000000},
    '{24'h7FFFFF, 1'b0, 24'h000000},
    '{24'h7FFFFF, 1'b0, 24'h000000},
    '{24'h800000, 1'b0, 24'h000000},
    '{24'h800000, 1'b0, 24'h000000},
    '{24'h800000, 1'b0, 24'h000000},
    '{24'h000001, 1'b0, 24'h000000},
    '{24'hFFFFFF, 1'b0, 24'h000000},
    '{24'h7FFFFF, 1'b0, 24'h000000},
    '{24'h000000, 1'b0, 24'h000000},
    '{24'h800000, 1'b0, 24'h000000},
    '{24'h2AAAAA, 1'b0, 24'h000000}
  };

  // DUT ports
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [SAMPLE_W-1:0]   s_tdata   = '0;   // [23:0] sample_in
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [SAMPLE_W-1:0]   m_tdata;          // [23:0] sample_out
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Filter model state
  logic [NUM_W-1:0]           num_coef [SECTIONS];
  logic [DEN_W-1:0]           den_coef [SECTIONS];
  logic signed [SAMPLE_W-1:0] x_hist   [SECTIONS][2];
  logic signed [SAMPLE_W-1:0] y_hist   [SECTIONS][2];

  // Filtered samples still owed by the block, oldest first
  logic [SAMPLE_W-1:0] filtered_due [$];

  // Bookkeeping
  int  mismatch_count   = 0;
  int  samples_sent     = 0;
  int  outputs_checked  = 0;
  int  settings_loaded  = 0;
  int  sat_events       = 0;
  int  idle_cycles      = 0;
  bit  long_hold_done   = 1'b0;
  bit  gaps_enabled     = 1'b1;
  int  burst_left       = 0;

  emg_three_biquad_cascade DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Filter model
  // ---------------------------------------------------------------------------

  function automatic void clear_filter_state();
    for (int s = 0; s < SECTIONS; s++) begin
      num_coef[s] = NUM_RESET;
      den_coef[s] = '0;
      for (int k = 0; k < 2; k++) begin
        x_hist[s][k] = '0;
        y_hist[s][k] = '0;
      end
    end
  endfunction

  // One direct-form-I section: exact MAC, round half up, saturate, update history
  function automatic logic [SAMPLE_W-1:0] run_section(input int s, input logic [SAMPLE_W-1:0] x_in);
    longint b0, b1, b2, a1, a2;
    longint x, x1, x2, y1, y2;
    longint acc, y;
    b0 = $signed(num_coef[s][0 +: COEF_W]);
    b1 = $signed(num_coef[s][COEF_W +: COEF_W]);
    b2 = $signed(num_coef[s][2*COEF_W +: COEF_W]);
    a1 = $signed(den_coef[s][0 +: COEF_W]);
    a2 = $signed(den_coef[s][COEF_W +: COEF_W]);
    x  = $signed(x_in);
    x1 = x_hist[s][0];
    x2 = x_hist[s][1];
    y1 = y_hist[s][0];
    y2 = y_hist[s][1];
    acc = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2 + (longint'(1) <<< (COEF_FRAC-1));
    y = acc >>> COEF_FRAC;
    if (y > SAT_HI) begin
      y = SAT_HI;
      sat_events++;
    end else if (y < SAT_LO) begin
      y = SAT_LO;
      sat_events++;
    end
    x_hist[s][1] = x_hist[s][0];
    x_hist[s][0] = x_in;
    y_hist[s][1] = y_hist[s][0];
    y_hist[s][0] = SAMPLE_W'(y);
    return SAMPLE_W'(y);
  endfunction

  function automatic logic [SAMPLE_W-1:0] filter_sample(input logic [SAMPLE_W-1:0] smp);
    logic [SAMPLE_W-1:0] v;
    v = smp;
    for (int s = 0; s < SECTIONS; s++) v = run_section(s, v);
    return v;
  endfunction

  // Mirror of a register write: unmapped indexes dropped, bits above the width dropped
  function automatic void apply_reg(input coef_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    int unsigned r;
    r = 32'(idx);
    if (r < NUM_REGS) begin
      if (r % 2 == 1) den_coef[r/2] = value[DEN_W-1:0];
      else num_coef[r/2] = value[NUM_W-1:0];
    end
  endfunction

  // Build one section's register pair; junk sits above the denominator fields
  function automatic void make_section(input coef_style_e style,
                                       output logic [NUM_W-1:0] num,
                                       output logic [CFG_DATA_W-1:0] den_raw);
    logic [COEF_W-1:0] c [5];
    for (int k = 0; k < 5; k++) begin
      unique case (style)
        STYLE_IDENTITY: c[k] = (k == 0) ? COEF_ONE : COEF_ZERO;
        STYLE_MAX:      c[k] = COEF_MAX;
        STYLE_MIN:      c[k] = COEF_MIN;
        STYLE_WILD:     c[k] = COEF_W'($urandom);
        default: begin
          // gains within +-0.5, feedback within +-0.25: stable, rarely clips
          if (k < 3) c[k] = COEF_W'($urandom_range(0, 65535)) - COEF_W'(32768);
          else c[k] = COEF_W'($urandom_range(0, 32767)) - COEF_W'(16384);
        end
      endcase
    end
    num     = {c[2], c[1], c[0]};
    den_raw = {COEF_W'($urandom), c[4], c[3]};
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Leaves cfg_we high; the caller lowers it after the last write of a group
  task automatic write_reg(input coef_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    apply_reg(idx, value);
  endtask

  // Offer one sample; on acceptance record its filtered value, then maybe idle
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input bit typed,
                             input logic [SAMPLE_W-1:0] typed_out);
    logic [SAMPLE_W-1:0] predicted;
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = filter_sample(smp);
    filtered_due.push_back(typed ? typed_out : predicted);
    samples_sent++;
    if (gaps_enabled) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        s_tvalid <= 1'b0;
        s_tdata  <= SAMPLE_W'($urandom);
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Sender pause: wait until every owed output has come back
  task automatic drain_outputs();
    s_tvalid <= 1'b0;
    while (filtered_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
                                 input logic [SAMPLE_W-1:0] want);
    $display("[%0t] MISMATCH %s: output %0d got %0d expected %0d", $realtime, what,
             outputs_checked, $signed(got), $signed(want));
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Output checker and watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] want;
    if (!rst) begin
      // compare each output transaction with the oldest owed sample
      if (m_tvalid && m_tready) begin
        if (filtered_due.size() == 0) begin
          report_mismatch("unexpected output", m_tdata, '0);
        end else begin
          want = filtered_due.pop_front();
          if (m_tdata !== want) report_mismatch("sample_out", m_tdata, want);
        end
        outputs_checked++;
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles, %0d outputs still owed",
                 WATCHDOG_LIMIT, filtered_due.size());
        $display("emg_three_biquad_cascade test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: changing stall patterns, plus one long hold-off
  // ---------------------------------------------------------------------------

  initial begin : receiver
    int mode;
    int span;
    int stall_left;
    stall_left = 0;
    wait (rst == 1'b0);
    forever begin
      if (!long_hold_done && outputs_checked >= HOLD_AT) begin
        // block fills up and must push back on the sender
        long_hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = $urandom_range(0, 4);
      span = $urandom_range(20, 200);
      repeat (span) begin
        unique case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 7) != 0);
          3: m_tready <= ($urandom_range(0, 3) == 0);
          default: begin
            if (stall_left == 0 && $urandom_range(0, 9) == 0) stall_left = $urandom_range(5, 60);
            m_tready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
          end
        endcase
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    coef_style_e         style;
    logic [NUM_W-1:0]    num;
    logic [CFG_DATA_W-1:0] den_raw;
    logic [SAMPLE_W-1:0] smp;
    int                  r;

    clear_filter_state();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: pass-through rows, then corner coefficients
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (i == FIRST_STRESS) begin
        drain_outputs();
        // -2.0, just under +2.0, 0 and 1.0; junk above the denominator fields
        write_reg(REG_HP_NUM,    {COEF_MIN, COEF_MAX, COEF_MIN});
        write_reg(REG_HP_DEN,    {JUNK_BITS, COEF_MIN, COEF_MAX});
        write_reg(REG_LP_NUM,    {COEF_ZERO, COEF_ZERO, COEF_MAX});
        write_reg(REG_LP_DEN,    {JUNK_BITS, COEF_MAX, COEF_MIN});
        write_reg(REG_NOTCH_NUM, {COEF_ONE, COEF_MIN, COEF_ONE});
        write_reg(REG_NOTCH_DEN, {JUNK_BITS, COEF_MAX, COEF_MIN});
        // writes past the last register must not land anywhere
        write_reg(REG_UNMAPPED_A, '1);
        write_reg(REG_UNMAPPED_B, '1);
        cfg_we <= 1'b0;
        settings_loaded++;
      end
      send_sample(directed[i].smp, directed[i].typed, directed[i].out);
    end

    // Random phases, each with a fresh coefficient setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_outputs();
      for (int s = 0; s < SECTIONS; s++) begin
        r = $urandom_range(0, 9);
        if (p == 0) style = STYLE_TAME;
        else if (p == 3) style = STYLE_MAX;
        else if (p == 5) style = STYLE_MIN;
        else if (r < 6) style = STYLE_TAME;
        else if (r < 8) style = STYLE_WILD;
        else style = STYLE_IDENTITY;
        make_section(style, num, den_raw);
        write_reg(coef_reg_e'(2*s), num);
        write_reg(coef_reg_e'(2*s + 1), den_raw);
      end
      if ($urandom_range(0, 1) == 1) write_reg(REG_UNMAPPED_A, CFG_DATA_W'({$urandom, $urandom}));
      if ($urandom_range(0, 1) == 1) write_reg(REG_UNMAPPED_B, CFG_DATA_W'({$urandom, $urandom}));
      cfg_we <= 1'b0;
      settings_loaded++;

      // one phase in four runs the sender flat out
      gaps_enabled = (p % 4 != 1);
      burst_left   = 0;

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        r = $urandom_range(0, 9);
        if (r < 6) smp = SAMPLE_W'($urandom);
        else if (r < 8) smp = SAMPLE_W'($urandom_range(0, 2000)) - SAMPLE_W'(1000);
        else if (r < 9) smp = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
        else smp = '0;
        send_sample(smp, 1'b0, '0);
      end
    end

    // Wind down
    drain_outputs();

    $display("Covered %0d samples over %0d coefficient settings, %0d outputs compared,",
             samples_sent, settings_loaded, outputs_checked);
    $display("%0d section saturations, long receiver hold-off %s, %0d mismatches",
             sat_events, long_hold_done ? "done" : "not reached", mismatch_count);
    if (mismatch_count == 0) begin
      $display("emg_three_biquad_cascade test passed");
    end else begin
      $display("emg_three_biquad_cascade test failed");
    end
    $finish;
  end

endmodule
